// ===== rtl/core/mnef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note event framer package
// Item types, command codes, status nibbles and phase encoding.
// ----------------------------------------------------------------------------
package mnef_pkg;

  localparam int RING_DEPTH_DEFAULT = 16;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [3:0] NOTE_OFF_TYPE = 4'h8;
  localparam logic [3:0] NOTE_ON_TYPE  = 4'h9;

  typedef enum logic [2:0] {
    PHASE_IDLE   = 3'b001,
    PHASE_FIRST  = 3'b010,
    PHASE_SECOND = 3'b100
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       event_valid;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
  } out_item_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
  } event_t;

endpackage

// ===== rtl/core/mnef_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module mnef_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/midi_note_event_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note event framer
// Frames note on/off events from serial MIDI bytes into a ring and pops them.
// ----------------------------------------------------------------------------
// Takes one item per cycle, byte or pop. A byte item updates the framing
// state and, on the second data byte, writes the whole three-byte event into
// one slot of the event RAM; it gives no result. A pop item gives one result
// after it is accepted, through the registered RAM read and then the output
// register. in_ready drops only while both the read stage and the output
// register are full and out_ready is low. The status byte is
// kept for running status. The ring has no full check: when the write slot
// wraps onto the read slot, pending events are lost. No clearing pass after
// reset.
// ----------------------------------------------------------------------------
module midi_note_event_framer #(
  parameter int RING_DEPTH = mnef_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mnef_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mnef_pkg::out_item_t out_data
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);

  mnef_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0]    write_slot_r, write_slot_nxt;
  logic [PW-1:0]    read_slot_r, read_slot_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [7:0]       first_r, first_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_hit_r, s1_hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  mnef_pkg::out_item_t out_item_r, out_item_nxt;

  logic             in_acc;
  logic             byte_acc;
  logic             pop_acc;
  logic             ring_empty;
  logic             is_note;
  logic             s1_adv;
  logic             wr_en;
  logic             rd_en;
  mnef_pkg::event_t wr_event;
  mnef_pkg::event_t rd_event;
  logic [PW-1:0]    write_slot_inc;
  logic [PW-1:0]    read_slot_inc;

  assign s1_adv     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_acc     = in_valid && in_ready;
  assign byte_acc   = in_acc && (in_data.command == mnef_pkg::CMD_BYTE);
  assign pop_acc    = in_acc && (in_data.command == mnef_pkg::CMD_POP);
  assign ring_empty = (read_slot_r == write_slot_r);
  assign is_note    = (in_data.rx_byte[7:4] == mnef_pkg::NOTE_ON_TYPE) ||
                      (in_data.rx_byte[7:4] == mnef_pkg::NOTE_OFF_TYPE);

  assign write_slot_inc = (write_slot_r == LAST_SLOT) ? '0 : write_slot_r + 1'b1;
  assign read_slot_inc  = (read_slot_r == LAST_SLOT) ? '0 : read_slot_r + 1'b1;

  assign wr_en    = byte_acc && !is_note && (phase_r == mnef_pkg::PHASE_SECOND);
  assign wr_event = '{status_byte: status_r, first_data: first_r,
                      second_data: in_data.rx_byte};
  assign rd_en    = pop_acc && !ring_empty;

  mnef_ram #(
    .WIDTH ($bits(mnef_pkg::event_t)),
    .DEPTH (RING_DEPTH)
  ) u_event_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_slot_r),
    .wr_data (wr_event),
    .rd_en   (rd_en),
    .rd_addr (read_slot_r),
    .rd_data (rd_event)
  );

  always_comb begin
    phase_nxt      = phase_r;
    status_nxt     = status_r;
    first_nxt      = first_r;
    write_slot_nxt = write_slot_r;
    if (byte_acc) begin
      if (is_note) begin
        status_nxt = in_data.rx_byte;
        phase_nxt  = mnef_pkg::PHASE_FIRST;
      end else begin
        unique case (phase_r)
          mnef_pkg::PHASE_FIRST: begin
            first_nxt = in_data.rx_byte;
            phase_nxt = mnef_pkg::PHASE_SECOND;
          end
          mnef_pkg::PHASE_SECOND: begin
            write_slot_nxt = write_slot_inc;
            phase_nxt      = mnef_pkg::PHASE_FIRST;
          end
          default: begin
            phase_nxt = mnef_pkg::PHASE_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    read_slot_nxt = rd_en ? read_slot_inc : read_slot_r;
    s1_hit_nxt    = pop_acc ? !ring_empty : s1_hit_r;
    if (pop_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      if (s1_hit_r) begin
        out_item_nxt = '{event_valid: 1'b1, status_byte: rd_event.status_byte,
                         first_data: rd_event.first_data,
                         second_data: rd_event.second_data};
      end else begin
        out_item_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= mnef_pkg::PHASE_IDLE;
      write_slot_r <= '0;
      read_slot_r  <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      write_slot_r <= write_slot_nxt;
      read_slot_r  <= read_slot_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    first_r    <= first_nxt;
    s1_hit_r   <= s1_hit_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_pop_hit_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_valid_r && s1_hit_r)
    else $error("pop of a nonempty ring did not reach the read stage");

  a_commit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> write_slot_r != $past(write_slot_r))
    else $error("event write did not advance the write slot");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule

// ===== test/midi_note_event_framer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note event framer checker
// Watches both channels of the framer and tracks the event ring on its own.
// Each accepted byte item updates the framing state and the ring. Each
// accepted pop item queues the event or empty answer that the block owes.
// Results are compared field by field, in order, against that queue.
// ----------------------------------------------------------------------------
module midi_note_event_framer_checker #(
  parameter int RING_DEPTH = mnef_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mnef_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mnef_pkg::out_item_t out_data,
  output int                  mismatch_count,
  output int                  pops_awaited
);

  mnef_pkg::event_t    ring [RING_DEPTH];
  int unsigned         wr_slot;
  int unsigned         rd_slot;
  mnef_pkg::phase_t    phase;
  mnef_pkg::out_item_t owed_pops [$];
  int                  errors;

  function automatic void frame_byte(logic [7:0] b);
    logic [7:0] carried;
    if (b[7:4] == mnef_pkg::NOTE_ON_TYPE || b[7:4] == mnef_pkg::NOTE_OFF_TYPE) begin
      ring[wr_slot].status_byte = b;
      phase = mnef_pkg::PHASE_FIRST;
    end else if (phase == mnef_pkg::PHASE_FIRST) begin
      ring[wr_slot].first_data = b;
      phase = mnef_pkg::PHASE_SECOND;
    end else if (phase == mnef_pkg::PHASE_SECOND) begin
      carried = ring[wr_slot].status_byte;
      ring[wr_slot].second_data = b;
      wr_slot = (wr_slot + 1) % RING_DEPTH;
      ring[wr_slot].status_byte = carried;
      phase = mnef_pkg::PHASE_FIRST;
    end
  endfunction

  function automatic mnef_pkg::out_item_t pop_event();
    mnef_pkg::out_item_t res;
    res = '0;
    if (rd_slot != wr_slot) begin
      res.event_valid = 1'b1;
      res.status_byte = ring[rd_slot].status_byte;
      res.first_data  = ring[rd_slot].first_data;
      res.second_data = ring[rd_slot].second_data;
      rd_slot = (rd_slot + 1) % RING_DEPTH;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_pop(mnef_pkg::out_item_t got);
    mnef_pkg::out_item_t want;
    if (owed_pops.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = owed_pops.pop_front();
    check_field("event_valid", {7'd0, want.event_valid}, {7'd0, got.event_valid});
    check_field("status_byte", want.status_byte, got.status_byte);
    check_field("first_data", want.first_data, got.first_data);
    check_field("second_data", want.second_data, got.second_data);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
      wr_slot = 0;
      rd_slot = 0;
      phase   = mnef_pkg::PHASE_IDLE;
      owed_pops.delete();
      errors  = 0;
    end else begin
      if (out_valid && out_ready) check_pop(out_data);
      if (in_valid && in_ready) begin
        if (in_data.command == mnef_pkg::CMD_POP) owed_pops.push_back(pop_event());
        else frame_byte(in_data.rx_byte);
      end
    end
    mismatch_count <= errors;
    pops_awaited   <= owed_pops.size();
  end

endmodule

// ===== test/midi_note_event_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI note event framer testbench
// Drives byte and pop items into the framer: a directed opening for the
// empty ring, ignored bytes, running status, status bytes taken as data and
// restarts, then random note events, pop bursts, ring overflows and noise.
// Both sides idle at random, and the receiver holds off for long stretches
// so that the framer stalls its input. A checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module midi_note_event_framer_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_OFF   = 400;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  mnef_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  mnef_pkg::out_item_t out_data;

  int mismatch_count;
  int pops_awaited;
  int items_sent = 0;
  int results_taken = 0;
  int idle_cycles = 0;
  int stall;
  int pick;

  midi_note_event_framer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  midi_note_event_framer_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .pops_awaited  (pops_awaited)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic send_item(mnef_pkg::in_item_t it);
    int gap;
    gap = (items_sent % 180 < 45) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item('{command: mnef_pkg::CMD_BYTE, rx_byte: b});
  endtask

  task automatic send_pop();
    send_item('{command: mnef_pkg::CMD_POP, rx_byte: 8'($urandom)});
  endtask

  task automatic send_note(bit fresh_status);
    if (fresh_status)
      send_byte({($urandom_range(0, 1) ? mnef_pkg::NOTE_ON_TYPE : mnef_pkg::NOTE_OFF_TYPE),
                 4'($urandom_range(0, 15))});
    repeat (2) begin
      if ($urandom_range(0, 7) == 0) send_byte(8'($urandom));
      else send_byte(8'($urandom_range(0, 127)));
    end
  endtask

  // receiver: random stalls, quiet stretches, and two long hold-offs
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_taken == 60 || results_taken == 180) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      stall = (results_taken % 150 < 40) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("midi_note_event_framer regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty ring, then bytes ignored while no event is open
    send_pop();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hF8);
    send_byte(8'hA5);
    // note on, then running status
    send_byte(8'h90);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h3C);
    send_byte(8'h40);
    // note off status, then other status bytes taken as data
    send_byte(8'h8F);
    send_byte(8'hFF);
    send_byte(8'hC0);
    // note status restarts an open event
    send_byte(8'h9A);
    send_byte(8'h80);
    send_byte(8'h12);
    send_byte(8'h34);
    repeat (5) send_pop();

    while (items_sent < 1120) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_note(1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_pop();
      end else if (pick < 88) begin
        // send notes that can fill past the ring depth, then drain
        repeat ($urandom_range(10, 20)) send_note(1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 20)) send_pop();
      end else begin
        send_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pops_awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pops_awaited == 0)
      $display("midi_note_event_framer regression: pass");
    else
      $display("midi_note_event_framer regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mnef_pkg.sv
rtl/core/mnef_ram.sv
rtl/core/midi_note_event_framer.sv
test/midi_note_event_framer_checker.sv
test/midi_note_event_framer_tb.sv
